FILE: sv/running_median_two_heaps_macros.svh
// Assertion macros for the running median block.
// Used by the top level, which includes this header by its bare name.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define RMH_ASSERT_NOW(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define RMH_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

FILE: sv/rmh_pkg.sv
// Package for the running median block: sizes, widths and the heap order test.
// Used by the interfaces and the top level through scoped names.
package rmh_pkg;

  localparam int HeapDepth = 512;
  localparam int AW        = $clog2(HeapDepth);
  localparam int SZ_W      = $clog2(HeapDepth + 1);
  localparam int IXW       = SZ_W + 1;
  localparam int DATA_W    = 32;
  localparam int MED_W     = 33;
  localparam int CNT_W     = 11;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [MED_W-1:0]  median_t;
  typedef logic [CNT_W-1:0]         count_t;

  // For the max-heap an entry ranks above another when it is greater.
  function automatic logic ranks_above(sample_t a, sample_t b, logic is_max);
    ranks_above = is_max ? (a > b) : (a < b);
  endfunction

endpackage

FILE: sv/sample_if.sv
// Input channel of the running median block: one sample per transaction.
// Depends on rmh_pkg for the sample type.
interface sample_if;
  logic             valid;
  logic             ready;
  rmh_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: sv/result_if.sv
// Output channel of the running median block: one result per transaction.
// Depends on rmh_pkg for the field types.
interface result_if;
  logic             valid;
  logic             ready;
  rmh_pkg::median_t median_doubled;
  rmh_pkg::count_t  held_count;
  logic             overflow;

  modport source (output valid, output median_doubled, output held_count,
                  output overflow, input ready);
  modport sink   (input valid, input median_doubled, input held_count,
                  input overflow, output ready);
endinterface

FILE: sv/running_median_two_heaps.sv
// Running median over a stream of signed samples, built on two heaps in RAM.
// Depends on rmh_pkg, sample_if, result_if and running_median_two_heaps_macros.svh.
//
// Usage: each transaction on samples carries one 32-bit signed sample. Each
// produces exactly one transaction on results: twice the running median, the
// number of samples held and an overflow flag. The lower half lives in a
// max-heap RAM, the upper half in a min-heap RAM, each with a registered read.
// An insert is a plain push, or a pop of one heap followed by two pushes.
// Each sift-up level reads the parent, then compares and writes; each
// sift-down level reads the left child, then the right child, then decides
// and writes. The heap depth and the single RAM read port per heap set the
// cost of an item. One item is worked at a time. When the store is full the
// sample is dropped and the result follows in the next cycle with overflow
// set. Reset empties both heaps at once; RAM contents are not cleared, since
// entries past the sizes are never used. When results stalls, the finished
// result waits in the output register and the next sample is held off until
// it is taken.
`include "running_median_two_heaps_macros.svh"

module running_median_two_heaps (
  input  logic       clk,
  input  logic       rst,
  sample_if.sink     samples,
  result_if.source   results
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_POP_RD   = 10'b0000000010,
    S_POP_LAST = 10'b0000000100,
    S_DN_RDL   = 10'b0000001000,
    S_DN_RDR   = 10'b0000010000,
    S_DN_DEC   = 10'b0000100000,
    S_PU_START = 10'b0001000000,
    S_PU_RD    = 10'b0010000000,
    S_PU_CMP   = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state;

  rmh_pkg::sample_t lo_mem [rmh_pkg::HeapDepth];
  rmh_pkg::sample_t up_mem [rmh_pkg::HeapDepth];
  rmh_pkg::sample_t lo_q, up_q;

  logic [rmh_pkg::SZ_W-1:0] lo_size, up_size, pop_n;
  rmh_pkg::sample_t lo_top, up_top;
  logic                     cur_lower;
  logic [rmh_pkg::AW-1:0]   idx;
  rmh_pkg::sample_t         hold, lval, moved, pend_v;
  logic                     second;

  logic                     out_valid, out_ovf, out_load;
  rmh_pkg::median_t         out_med;
  rmh_pkg::count_t          out_cnt;

  logic                     wr_en, rd_en;
  logic [rmh_pkg::AW-1:0]   wr_addr, rd_addr;
  rmh_pkg::sample_t         wr_data, rdat, bval;
  logic [rmh_pkg::IXW-1:0]  l_ix, r_ix, n_ix;
  logic [rmh_pkg::AW-1:0]   p_ix;
  logic                     l_ok, r_ok, climb, out_free, full, accept;
  rmh_pkg::median_t         med_now;
  rmh_pkg::count_t          cnt_now;
  logic [rmh_pkg::SZ_W:0]   total;

  assign rdat  = cur_lower ? lo_q : up_q;
  assign l_ix  = rmh_pkg::IXW'({idx, 1'b1});
  assign r_ix  = l_ix + rmh_pkg::IXW'(1);
  assign n_ix  = rmh_pkg::IXW'(pop_n);
  assign p_ix  = (idx - rmh_pkg::AW'(1)) >> 1;
  assign l_ok  = (l_ix < n_ix) && rmh_pkg::ranks_above(lval, hold, cur_lower);
  assign bval  = l_ok ? lval : hold;
  assign r_ok  = (r_ix < n_ix) && rmh_pkg::ranks_above(rdat, bval, cur_lower);
  assign climb = rmh_pkg::ranks_above(hold, rdat, cur_lower);

  assign total    = {1'b0, lo_size} + {1'b0, up_size};
  assign cnt_now  = rmh_pkg::CNT_W'(total);
  assign full     = total >= (rmh_pkg::SZ_W+1)'(2 * rmh_pkg::HeapDepth);
  assign out_free = !out_valid || results.ready;
  assign accept   = samples.valid && samples.ready;
  assign out_load = ((state == S_DONE) && out_free) || (accept && full);

  always_comb begin
    if (lo_size == up_size) begin
      if (lo_size == '0) begin
        med_now = '0;
      end else begin
        med_now = rmh_pkg::MED_W'(lo_top) + rmh_pkg::MED_W'(up_top);
      end
    end else if (lo_size > up_size) begin
      med_now = {lo_top, 1'b0};
    end else begin
      med_now = {up_top, 1'b0};
    end
  end

  // Memory port control for the current state.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = hold;
    rd_en   = 1'b0;
    rd_addr = idx;
    case (state)
      S_POP_RD: begin
        rd_en   = 1'b1;
        rd_addr = pop_n[rmh_pkg::AW-1:0];
      end
      S_DN_RDL: begin
        rd_en   = 1'b1;
        rd_addr = l_ix[rmh_pkg::AW-1:0];
      end
      S_DN_RDR: begin
        rd_en   = 1'b1;
        rd_addr = r_ix[rmh_pkg::AW-1:0];
      end
      S_DN_DEC: begin
        wr_en   = 1'b1;
        wr_data = r_ok ? rdat : bval;
      end
      S_PU_RD: begin
        if (idx == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = p_ix;
        end
      end
      S_PU_CMP: begin
        wr_en   = 1'b1;
        wr_data = climb ? rdat : hold;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en && cur_lower) begin
      lo_mem[wr_addr] <= wr_data;
    end
    if (wr_en && !cur_lower) begin
      up_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      lo_q <= lo_mem[rd_addr];
      up_q <= up_mem[rd_addr];
    end
  end

  // Copies of entry zero, so the placement rules never wait on a RAM read.
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == '0) begin
      if (cur_lower) begin
        lo_top <= wr_data;
      end else begin
        up_top <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lo_size   <= '0;
      up_size   <= '0;
      second    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend_v <= samples.sample;
            hold   <= samples.sample;
            second <= 1'b0;
            if (full) begin
              out_med   <= med_now;
              out_cnt   <= cnt_now;
              out_ovf   <= 1'b1;
            end else if (lo_size == up_size) begin
              cur_lower <= (lo_size == '0) || (lo_top > samples.sample);
              state     <= S_PU_START;
            end else if (lo_size > up_size) begin
              if (samples.sample >= lo_top) begin
                cur_lower <= 1'b0;
                state     <= S_PU_START;
              end else begin
                cur_lower <= 1'b1;
                moved     <= lo_top;
                pop_n     <= lo_size - rmh_pkg::SZ_W'(1);
                lo_size   <= lo_size - rmh_pkg::SZ_W'(1);
                state     <= S_POP_RD;
              end
            end else begin
              if (samples.sample <= up_top) begin
                cur_lower <= 1'b1;
                state     <= S_PU_START;
              end else begin
                cur_lower <= 1'b0;
                moved     <= up_top;
                pop_n     <= up_size - rmh_pkg::SZ_W'(1);
                up_size   <= up_size - rmh_pkg::SZ_W'(1);
                state     <= S_POP_RD;
              end
            end
          end
        end
        S_POP_RD: begin
          state <= S_POP_LAST;
        end
        S_POP_LAST: begin
          hold  <= rdat;
          idx   <= '0;
          state <= S_DN_RDL;
        end
        S_DN_RDL: begin
          state <= S_DN_RDR;
        end
        S_DN_RDR: begin
          lval  <= rdat;
          state <= S_DN_DEC;
        end
        S_DN_DEC: begin
          if (r_ok) begin
            idx   <= r_ix[rmh_pkg::AW-1:0];
            state <= S_DN_RDL;
          end else if (l_ok) begin
            idx   <= l_ix[rmh_pkg::AW-1:0];
            state <= S_DN_RDL;
          end else begin
            // The popped top now goes to the other heap, then the sample follows.
            cur_lower <= !cur_lower;
            hold      <= moved;
            second    <= 1'b1;
            state     <= S_PU_START;
          end
        end
        S_PU_START: begin
          if (cur_lower) begin
            idx     <= lo_size[rmh_pkg::AW-1:0];
            lo_size <= lo_size + rmh_pkg::SZ_W'(1);
          end else begin
            idx     <= up_size[rmh_pkg::AW-1:0];
            up_size <= up_size + rmh_pkg::SZ_W'(1);
          end
          state <= S_PU_RD;
        end
        S_PU_RD, S_PU_CMP: begin
          if (state == S_PU_CMP && climb) begin
            idx   <= p_ix;
            state <= S_PU_RD;
          end else if (state == S_PU_RD && idx != '0) begin
            state <= S_PU_CMP;
          end else if (second) begin
            second    <= 1'b0;
            cur_lower <= !cur_lower;
            hold      <= pend_v;
            state     <= S_PU_START;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_med   <= med_now;
            out_cnt   <= cnt_now;
            out_ovf   <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign samples.ready          = (state == S_IDLE) && out_free;
  assign results.valid          = out_valid;
  assign results.median_doubled = out_med;
  assign results.held_count     = out_cnt;
  assign results.overflow       = out_ovf;

  `RMH_ASSERT_NOW(a_balanced, clk, rst, state == S_IDLE, (lo_size == up_size) || (lo_size == up_size + rmh_pkg::SZ_W'(1)) || (up_size == lo_size + rmh_pkg::SZ_W'(1)))
  `RMH_ASSERT_NOW(a_idle_no_write, clk, rst, state == S_IDLE, !wr_en)
  `RMH_ASSERT_NEXT(a_dropped_repeats, clk, rst, accept && full, out_valid && out_ovf && $stable(lo_size) && $stable(up_size))

endmodule

FILE: test/running_median_two_heaps_tb.sv
// Self-checking testbench for the running median block on two heaps.
// Depends on rmh_pkg, sample_if, result_if and running_median_two_heaps.
module running_median_two_heaps_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sample_if samples_ch ();
  result_if results_ch ();

  running_median_two_heaps u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch.sink),
    .results (results_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    rmh_pkg::median_t med;
    rmh_pkg::count_t  cnt;
    logic             ovf;
  } median_result_t;

  rmh_pkg::sample_t pending_samples[$];
  median_result_t   expected_medians[$];
  int               src_idle_pct = 0;
  int               snk_idle_pct = 0;
  int               error_count = 0;
  int               results_seen = 0;
  int               overflow_seen = 0;
  bit               in_fire = 1'b0;

  // Predictor state: lower half as a max-heap, upper half as a min-heap.
  longint lo_heap[rmh_pkg::HeapDepth];
  longint hi_heap[rmh_pkg::HeapDepth];
  int     lo_n;
  int     hi_n;

  function automatic bit outranks(longint a, longint b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  function automatic void heap_add(ref longint h[rmh_pkg::HeapDepth], ref int n,
                                   input longint v, input bit is_max);
    int i;
    int p;
    longint t;
    i = n;
    h[i] = v;
    n = n + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!outranks(h[i], h[p], is_max)) break;
      t = h[i]; h[i] = h[p]; h[p] = t;
      i = p;
    end
  endfunction

  function automatic void heap_take(ref longint h[rmh_pkg::HeapDepth], ref int n,
                                    input bit is_max, output longint top);
    int i;
    int l;
    int best;
    longint t;
    top = h[0];
    n = n - 1;
    h[0] = h[n];
    i = 0;
    forever begin
      l = 2 * i + 1;
      best = i;
      if (l < n && outranks(h[l], h[best], is_max)) best = l;
      if (l + 1 < n && outranks(h[l + 1], h[best], is_max)) best = l + 1;
      if (best == i) break;
      t = h[i]; h[i] = h[best]; h[best] = t;
      i = best;
    end
  endfunction

  function automatic median_result_t insert_and_predict(rmh_pkg::sample_t s);
    median_result_t r;
    longint v;
    longint moved;
    longint med;
    v = longint'(s);
    r.ovf = 1'b0;
    if (lo_n + hi_n >= 2 * rmh_pkg::HeapDepth) begin
      r.ovf = 1'b1;
    end else if (lo_n == hi_n) begin
      if (lo_n == 0 || lo_heap[0] > v) heap_add(lo_heap, lo_n, v, 1'b1);
      else heap_add(hi_heap, hi_n, v, 1'b0);
    end else if (lo_n > hi_n) begin
      if (v >= lo_heap[0]) begin
        heap_add(hi_heap, hi_n, v, 1'b0);
      end else begin
        heap_take(lo_heap, lo_n, 1'b1, moved);
        heap_add(hi_heap, hi_n, moved, 1'b0);
        heap_add(lo_heap, lo_n, v, 1'b1);
      end
    end else begin
      if (v <= hi_heap[0]) begin
        heap_add(lo_heap, lo_n, v, 1'b1);
      end else begin
        heap_take(hi_heap, hi_n, 1'b0, moved);
        heap_add(lo_heap, lo_n, moved, 1'b1);
        heap_add(hi_heap, hi_n, v, 1'b0);
      end
    end
    if (lo_n == hi_n) med = (lo_n == 0) ? 0 : lo_heap[0] + hi_heap[0];
    else if (lo_n > hi_n) med = 2 * lo_heap[0];
    else med = 2 * hi_heap[0];
    r.med = rmh_pkg::median_t'(med);
    r.cnt = rmh_pkg::count_t'(lo_n + hi_n);
    return r;
  endfunction

  // Driver: presents queued samples, holding valid until the transaction.
  always @(negedge clk) begin
    if (rst) begin
      samples_ch.valid <= 1'b0;
      samples_ch.sample <= '0;
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      if (!samples_ch.valid || in_fire) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          samples_ch.valid <= 1'b1;
          samples_ch.sample <= pending_samples[0];
        end else begin
          samples_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on accepted samples, checks accepted results.
  always @(posedge clk) begin
    median_result_t e;
    in_fire = !rst && samples_ch.valid && samples_ch.ready;
    if (!rst) begin
      if (samples_ch.valid && samples_ch.ready) begin
        void'(pending_samples.pop_front());
        expected_medians.push_back(insert_and_predict(samples_ch.sample));
      end
      if (results_ch.valid && results_ch.ready) begin
        results_seen++;
        if (results_ch.overflow) overflow_seen++;
        if (expected_medians.size() == 0) begin
          $display("%0t: unexpected result med=%0d cnt=%0d ovf=%0b", $time,
                   results_ch.median_doubled, results_ch.held_count,
                   results_ch.overflow);
          error_count++;
        end else begin
          e = expected_medians.pop_front();
          if (results_ch.median_doubled !== e.med) begin
            $display("%0t: median_doubled expected %0d actual %0d", $time, e.med,
                     results_ch.median_doubled);
            error_count++;
          end
          if (results_ch.held_count !== e.cnt) begin
            $display("%0t: held_count expected %0d actual %0d", $time, e.cnt,
                     results_ch.held_count);
            error_count++;
          end
          if (results_ch.overflow !== e.ovf) begin
            $display("%0t: overflow expected %0b actual %0b", $time, e.ovf,
                     results_ch.overflow);
            error_count++;
          end
        end
      end
    end
  end

  function automatic rmh_pkg::sample_t pick_sample(int mode);
    case (mode)
      0: return rmh_pkg::sample_t'($urandom);
      1: return rmh_pkg::sample_t'($urandom_range(40)) - 20;
      2: return ($urandom_range(1)) ? 32'sh7fff_ffff - $urandom_range(3)
                                    : 32'sh8000_0000 + $urandom_range(3);
      default: return rmh_pkg::sample_t'($urandom_range(1000));
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_samples.size() > 0 || expected_medians.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int k;
    samples_ch.valid = 1'b0;
    samples_ch.sample = '0;
    results_ch.ready = 1'b0;
    lo_n = 0;
    hi_n = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, equal values, and both rebalancing directions.
    src_idle_pct = 13;
    snk_idle_pct = 65;
    pending_samples = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                        32'sh8000_0000, 32'sh8000_0000, 0, -1, 1, 5, 5, 5,
                        32'sh5555_5555, 32'shaaaa_aaaa, 100, -100, 7, 6, 8};
    wait_drained();

    // Random phase one: mixed value styles.
    for (k = 0; k < 280; k++) pending_samples.push_back(pick_sample($urandom_range(3)));
    wait_drained();

    src_idle_pct = 65;
    snk_idle_pct = 13;
    for (k = 0; k < 280; k++) pending_samples.push_back(pick_sample($urandom_range(3)));
    wait_drained();

    // Back to back with no idling on either side.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (k = 0; k < 272; k++) pending_samples.push_back(pick_sample($urandom_range(3)));
    wait_drained();
    repeat (100) @(posedge clk);

    $display("Checked %0d results, %0d with samples dropped on a full store.",
             results_seen, overflow_seen);
    if (error_count == 0 && expected_medians.size() == 0)
      $display("running_median_two_heaps test passed");
    else
      $display("running_median_two_heaps test failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("running_median_two_heaps test failed");
    $finish;
  end
endmodule
